>>> hdl/assert_macros.svh
// Assertion macros shared by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DCCP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/dccp_pkg.sv
// Shared types and constants for the degree/co-degree core peeling block.
// No dependencies; imported by every module of the block.
`default_nettype none

package dccp_pkg;

    localparam int CFG_W       = 9;
    localparam int CHUNK_W     = 32;
    localparam int CHUNK_SUM_W = $clog2(CHUNK_W + 1);

    localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
    localparam logic [1:0] REG_MIN_DEGREE    = 2'd1;
    localparam logic [1:0] REG_MIN_NONDEGREE = 2'd2;

    typedef enum logic [7:0] {
        ST_CLR   = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_WRB   = 8'b0000_0100,
        ST_INIT  = 8'b0000_1000,
        ST_VISIT = 8'b0001_0000,
        ST_POP   = 8'b0010_0000,
        ST_CHECK = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic step;
        logic clear;
    } pop_ctl_t;

    function automatic logic [2:0] nib_pop(input logic [3:0] x);
        return 3'(x[0]) + 3'(x[1]) + 3'(x[2]) + 3'(x[3]);
    endfunction

endpackage

`default_nettype wire

>>> hdl/dccp_adj_ram.sv
// Adjacency bit matrix: one row per vertex, bit-set or whole-row clear on
// the write port, registered read of a full row. Uses dccp_pkg.
`default_nettype none

module dccp_adj_ram
    import dccp_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    localparam int VTX_W  = $clog2(MAX_VERTICES),
    localparam int NCHUNK = (MAX_VERTICES + CHUNK_W - 1) / CHUNK_W,
    localparam int ROW_W  = NCHUNK * CHUNK_W,
    localparam int IDX_W  = $clog2(ROW_W)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic             wclr,
    input  wire logic [VTX_W-1:0] waddr,
    input  wire logic [IDX_W-1:0] wbit,
    input  wire logic             re,
    input  wire logic [VTX_W-1:0] raddr,
    output logic      [ROW_W-1:0] rdata
);

    logic [ROW_W-1:0] mem [MAX_VERTICES];

    // per-bit write enables: all bits on clear, one bit on set
    always_ff @(posedge aclk) begin
        if (we) begin
            for (int i = 0; i < ROW_W; i++) begin
                if (wclr || (wbit == IDX_W'(i))) begin
                    mem[waddr][i] <= !wclr;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/dccp_pop_unit.sv
// Shared population-count accumulator: adds the ones of one 32-bit chunk
// per step. Uses dccp_pkg for the chunk width and nibble count.
`default_nettype none

module dccp_pop_unit
    import dccp_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
    input  wire logic               aclk,
    input  wire pop_ctl_t           ctl,
    input  wire logic [CHUNK_W-1:0] chunk,
    output logic      [CNT_W-1:0]   count
);

    logic [CHUNK_SUM_W-1:0] sum;
    logic [CNT_W-1:0]       count_reg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < CHUNK_W / 4; i++) begin
            sum = sum + CHUNK_SUM_W'(nib_pop(chunk[i*4 +: 4]));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.step) begin
            count_reg <= ctl.clear ? CNT_W'(sum) : count_reg + CNT_W'(sum);
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

>>> hdl/dccp_ctrl.sv
// Sequencer: edge loading, peeling passes over the vertices, result
// register and matrix clearing. Uses dccp_pkg; drives dccp_adj_ram and
// dccp_pop_unit.
`default_nettype none

module dccp_ctrl
    import dccp_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    localparam int VTX_W  = $clog2(MAX_VERTICES),
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1),
    localparam int NCHUNK = (MAX_VERTICES + CHUNK_W - 1) / CHUNK_W,
    localparam int ROW_W  = NCHUNK * CHUNK_W,
    localparam int IDX_W  = $clog2(ROW_W),
    localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1,
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_end_a,
    input  wire logic [7:0]         s_end_b,
    input  wire logic               s_has_edge,
    input  wire logic               s_last_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [8:0]         m_remaining_count,
    input  wire logic [CFG_W-1:0]   vertex_count,
    input  wire logic [CFG_W-1:0]   min_degree,
    input  wire logic [CFG_W-1:0]   min_nondegree,
    output logic                    ram_we,
    output logic                    ram_wclr,
    output logic      [VTX_W-1:0]   ram_waddr,
    output logic      [IDX_W-1:0]   ram_wbit,
    output logic                    ram_re,
    output logic      [VTX_W-1:0]   ram_raddr,
    input  wire logic [ROW_W-1:0]   ram_rdata,
    output pop_ctl_t                pop_ctl,
    output logic      [CHUNK_W-1:0] pop_chunk,
    input  wire logic [CNT_W-1:0]   pop_count
);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        v_reg;
    logic [KW-1:0]           chunk_reg;
    logic                    changed_reg;
    logic [CNT_W-1:0]        total_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [MAX_VERTICES-1:0] alive_reg;
    logic [VTX_W-1:0]        a_reg, b_reg;
    logic                    last_reg;
    logic                    m_valid_reg;
    logic [8:0]              m_count_reg;

    logic [CNT_W-1:0] cfg_n;
    logic             edge_ok;
    logic [VTX_W-1:0] v_idx;
    logic             v_at_end;
    logic             alive_bit;
    logic             clr_last;
    logic             chunk_last;
    logic [ROW_W-1:0] alive_pad;
    logic [CNT_W-1:0] nondeg;
    logic             remove;

    // vertex count in use, saturated to the array size
    assign cfg_n = (CMP_W'(vertex_count) > CMP_W'(MAX_VERTICES)) ?
                   CNT_W'(MAX_VERTICES) : CNT_W'(vertex_count);

    assign edge_ok = s_has_edge && (s_end_a != s_end_b)
                     && (CMP_W'(s_end_a) < CMP_W'(cfg_n))
                     && (CMP_W'(s_end_b) < CMP_W'(cfg_n));

    assign v_idx      = v_reg[VTX_W-1:0];
    assign v_at_end   = (v_reg == n_reg);
    assign alive_bit  = alive_reg[v_idx];
    assign clr_last   = (v_reg == CNT_W'(MAX_VERTICES - 1));
    assign chunk_last = (chunk_reg == KW'(NCHUNK - 1));
    assign alive_pad  = ROW_W'(alive_reg);

    assign pop_chunk = ram_rdata[chunk_reg*CHUNK_W +: CHUNK_W]
                     & alive_pad[chunk_reg*CHUNK_W +: CHUNK_W];

    // v is live here, so the live total exceeds its degree
    assign nondeg = total_reg - CNT_W'(1) - pop_count;
    assign remove = (CMP_W'(pop_count) < CMP_W'(min_degree))
                 || (CMP_W'(nondeg) < CMP_W'(min_nondegree));

    always_comb begin
        state_next    = state_reg;
        ram_we        = 1'b0;
        ram_wclr      = 1'b0;
        ram_waddr     = v_idx;
        ram_wbit      = '0;
        ram_re        = 1'b0;
        ram_raddr     = v_idx;
        pop_ctl.step  = 1'b0;
        pop_ctl.clear = 1'b0;
        case (state_reg)
            ST_CLR: begin
                ram_we   = 1'b1;
                ram_wclr = 1'b1;
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (edge_ok) begin
                        ram_we     = 1'b1;
                        ram_waddr  = VTX_W'(s_end_a);
                        ram_wbit   = IDX_W'(s_end_b);
                        state_next = ST_WRB;
                    end else if (s_last_item) begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_WRB: begin
                ram_we     = 1'b1;
                ram_waddr  = b_reg;
                ram_wbit   = IDX_W'(a_reg);
                state_next = last_reg ? ST_INIT : ST_IDLE;
            end
            ST_INIT: begin
                state_next = ST_VISIT;
            end
            ST_VISIT: begin
                if (v_at_end) begin
                    state_next = changed_reg ? ST_VISIT : ST_DONE;
                end else if (alive_bit) begin
                    ram_re     = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                pop_ctl.step  = 1'b1;
                pop_ctl.clear = (chunk_reg == '0);
                if (chunk_last) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_VISIT;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_CLR;
                end
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // in ST_DONE the result load below owns m_valid_reg
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLR: begin
                    v_reg <= clr_last ? '0 : v_reg + CNT_W'(1);
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        a_reg    <= VTX_W'(s_end_a);
                        b_reg    <= VTX_W'(s_end_b);
                        last_reg <= s_last_item;
                    end
                end
                ST_INIT: begin
                    for (int i = 0; i < MAX_VERTICES; i++) begin
                        alive_reg[i] <= (CMP_W'(i) < CMP_W'(cfg_n));
                    end
                    total_reg   <= cfg_n;
                    n_reg       <= cfg_n;
                    v_reg       <= '0;
                    changed_reg <= 1'b0;
                end
                ST_VISIT: begin
                    if (v_at_end) begin
                        if (changed_reg) begin
                            v_reg       <= '0;
                            changed_reg <= 1'b0;
                        end
                    end else if (!alive_bit) begin
                        v_reg <= v_reg + CNT_W'(1);
                    end else begin
                        chunk_reg <= '0;
                    end
                end
                ST_POP: begin
                    chunk_reg <= chunk_reg + KW'(1);
                end
                ST_CHECK: begin
                    if (remove) begin
                        alive_reg[v_idx] <= 1'b0;
                        total_reg        <= total_reg - CNT_W'(1);
                        changed_reg      <= 1'b1;
                    end
                    v_reg <= v_reg + CNT_W'(1);
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_count_reg <= 9'(total_reg);
                        v_reg       <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_remaining_count = m_count_reg;

endmodule

`default_nettype wire

>>> hdl/degree_and_codegree_core_peel_top.sv
// Top level of the degree/co-degree core peeling block: APB registers and
// the sequencer, adjacency RAM and popcount unit. Uses dccp_pkg.
//
// Usage: edges arrive one word per handshake on the s_ channel (end_a,
// end_b, has_edge, last_item). An item with a valid edge writes both
// matrix rows, end_a's on acceptance, then end_b's with s_ready low;
// other items write nothing. The word marked last_item starts the peel:
// the sequencer walks vertices 0..n-1 in passes until a pass removes
// nothing. A live vertex takes a row read, one 32-bit popcount chunk
// per cycle through the shared counter and a compare, a dead one is
// skipped; at most n+1 passes run. The count of survivors goes out as
// one m_ word and is held in an output register until taken; meanwhile
// the next peel can run, but its result waits. After each result, and
// after reset, a clearing pass zeroes all MAX_VERTICES rows of the
// adjacency RAM one row per cycle with s_ready low; APB writes are taken
// at any time. Reset (aresetn, synchronous, active low) restores
// vertex_count 256, min_degree 0, min_nondegree 0 and drops m_valid.
`default_nettype none

module degree_and_codegree_core_peel_top
    import dccp_pkg::*;
#(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_end_a,
    input  wire logic [7:0]  s_end_b,
    input  wire logic        s_has_edge,
    input  wire logic        s_last_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [8:0]  m_remaining_count,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int VTX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int NCHUNK = (MAX_VERTICES + CHUNK_W - 1) / CHUNK_W;
    localparam int ROW_W  = NCHUNK * CHUNK_W;
    localparam int IDX_W  = $clog2(ROW_W);

    logic [CFG_W-1:0] vertex_count_reg;
    logic [CFG_W-1:0] min_degree_reg;
    logic [CFG_W-1:0] min_nondegree_reg;
    logic [1:0]       reg_idx;
    logic             cfg_wr;

    logic               ram_we, ram_wclr, ram_re;
    logic [VTX_W-1:0]   ram_waddr, ram_raddr;
    logic [IDX_W-1:0]   ram_wbit;
    logic [ROW_W-1:0]   ram_rdata;
    pop_ctl_t           pop_ctl;
    logic [CHUNK_W-1:0] pop_chunk;
    logic [CNT_W-1:0]   pop_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg  <= CFG_W'(256);
            min_degree_reg    <= '0;
            min_nondegree_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_VERTEX_COUNT:  vertex_count_reg  <= pwdata[CFG_W-1:0];
                REG_MIN_DEGREE:    min_degree_reg    <= pwdata[CFG_W-1:0];
                REG_MIN_NONDEGREE: min_nondegree_reg <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_VERTEX_COUNT:  prdata = 32'(vertex_count_reg);
            REG_MIN_DEGREE:    prdata = 32'(min_degree_reg);
            REG_MIN_NONDEGREE: prdata = 32'(min_nondegree_reg);
            default:           prdata = '0;
        endcase
    end

    dccp_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_end_a           (s_end_a),
        .s_end_b           (s_end_b),
        .s_has_edge        (s_has_edge),
        .s_last_item       (s_last_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_remaining_count (m_remaining_count),
        .vertex_count      (vertex_count_reg),
        .min_degree        (min_degree_reg),
        .min_nondegree     (min_nondegree_reg),
        .ram_we            (ram_we),
        .ram_wclr          (ram_wclr),
        .ram_waddr         (ram_waddr),
        .ram_wbit          (ram_wbit),
        .ram_re            (ram_re),
        .ram_raddr         (ram_raddr),
        .ram_rdata         (ram_rdata),
        .pop_ctl           (pop_ctl),
        .pop_chunk         (pop_chunk),
        .pop_count         (pop_count)
    );

    dccp_adj_ram #(.MAX_VERTICES(MAX_VERTICES)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .wclr  (ram_wclr),
        .waddr (ram_waddr),
        .wbit  (ram_wbit),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dccp_pop_unit #(.MAX_VERTICES(MAX_VERTICES)) u_pop (
        .aclk  (aclk),
        .ctl   (pop_ctl),
        .chunk (pop_chunk),
        .count (pop_count)
    );

endmodule

`default_nettype wire

>>> hdl/dccp_checker.sv
// Port-level checker for the core peeling top, attached by bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dccp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       s_last_item,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [8:0] m_remaining_count
);

    // the peel starts right after the last word; no word is taken then
    `DCCP_ASSERT_NEXT(a_last_blocks, aclk, aresetn, s_valid && s_ready && s_last_item, !s_ready, "input taken right after last word")

    // a result is only produced after a last word, never in the cycle after a plain word
    `DCCP_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_valid && s_ready && !s_last_item, !$rose(m_valid), "result right after a non-last word")

    // a new result appears while the matrix is being cleared
    `DCCP_ASSERT(a_result_while_busy, aclk, aresetn, $rose(m_valid) |-> !s_ready, "result appeared while input was open")

    // stalled result word holds
    `DCCP_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_remaining_count), "stalled result changed")

endmodule

bind degree_and_codegree_core_peel_top dccp_checker u_dccp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_last_item       (s_last_item),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_remaining_count (m_remaining_count)
);

`default_nettype wire

>>> tb/tb.sv
// Testbench for degree_and_codegree_core_peel_top: graph loads on the s_ channel,
// config over APB, and a behavioral peeling predictor that checks every m_ word.
// Depends on dccp_pkg and the RTL of the block.
`default_nettype none

module tb;
    import dccp_pkg::*;

    localparam int unsigned MAXV         = 256;
    localparam int unsigned RANDOM_EDGES = 2000;
    localparam int unsigned LONG_HOLD    = 30000;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam longint unsigned CYCLE_LIMIT = 64_000_000;
    localparam logic [1:0]  REG_SPARE    = 2'd3;   // unmapped, writes dropped

    typedef struct packed {
        logic [7:0] end_a;
        logic [7:0] end_b;
        logic       has_edge;
        logic       last_item;
    } edge_word_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_end_a     = 8'd0;
    logic [7:0]  s_end_b     = 8'd0;
    logic        s_has_edge  = 1'b0;
    logic        s_last_item = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [8:0]  m_remaining_count;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = 4'd0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    degree_and_codegree_core_peel_top #(
        .MAX_VERTICES(MAXV)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_end_a           (s_end_a),
        .s_end_b           (s_end_b),
        .s_has_edge        (s_has_edge),
        .s_last_item       (s_last_item),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_remaining_count (m_remaining_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow of the block: config, adjacency matrix, pending words, expected counts
    logic [8:0]      cfg_vertex_count  = 9'd256;
    logic [8:0]      cfg_min_degree    = 9'd0;
    logic [8:0]      cfg_min_nondegree = 9'd0;
    bit [MAXV-1:0]   adj_rows [MAXV];
    edge_word_t      edge_words [$];
    logic [8:0]      survivor_counts [$];

    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     edges_loaded   = 0;
    int unsigned     mismatches     = 0;
    bit              hold_start     = 1'b0;
    bit              hold_taken;
    int unsigned     hold_left;
    longint unsigned cycle_count    = 0;
    edge_word_t      word_out;
    logic [8:0]      want;

    function automatic int unsigned live_limit();
        return (cfg_vertex_count > MAXV) ? MAXV : int'(cfg_vertex_count);
    endfunction

    // fixed-point removal; the surviving set does not depend on visit order
    function automatic logic [8:0] peel_survivors();
        int unsigned   n;
        int unsigned   total;
        int unsigned   nondeg;
        int unsigned   deg [MAXV];
        bit [MAXV-1:0] alive;
        bit            changed;
        n = live_limit();
        alive = '0;
        for (int unsigned v = 0; v < n; v++) alive[v] = 1'b1;
        total = n;
        for (int unsigned v = 0; v < n; v++) deg[v] = $countones(adj_rows[v] & alive);
        changed = 1'b1;
        while (changed) begin
            changed = 1'b0;
            for (int unsigned v = 0; v < n; v++) begin
                if (alive[v]) begin
                    nondeg = total - 1 - deg[v];
                    if (deg[v] < cfg_min_degree || nondeg < cfg_min_nondegree) begin
                        alive[v] = 1'b0;
                        total--;
                        for (int unsigned u = 0; u < n; u++) begin
                            if (alive[u] && adj_rows[v][u] && deg[u] > 0) deg[u]--;
                        end
                        changed = 1'b1;
                    end
                end
            end
        end
        return total[8:0];
    endfunction

    function automatic void load_word(input edge_word_t w);
        int unsigned n;
        n = live_limit();
        if (w.has_edge && w.end_a != w.end_b && w.end_a < n && w.end_b < n) begin
            adj_rows[w.end_a][w.end_b] = 1'b1;
            adj_rows[w.end_b][w.end_a] = 1'b1;
        end
        if (w.last_item) begin
            survivor_counts = {survivor_counts, peel_survivors()};
            for (int unsigned v = 0; v < MAXV; v++) adj_rows[v] = '0;
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) load_word({s_end_a, s_end_b, s_has_edge, s_last_item});
            if (edge_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                word_out = edge_words.pop_front();
                s_end_a     <= word_out.end_a;
                s_end_b     <= word_out.end_b;
                s_has_edge  <= word_out.has_edge;
                s_last_item <= word_out.last_item;
                s_valid     <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_taken <= 1'b0;
            hold_left  <= 0;
        end else if (hold_start && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (survivor_counts.size() == 0) begin
                $error("remaining_count: word with nothing expected, actual %0d",
                       m_remaining_count);
                mismatches++;
            end else begin
                want = survivor_counts.pop_front();
                if (m_remaining_count !== want) begin
                    $error("remaining_count: expected %0d, actual %0d",
                           want, m_remaining_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & 32'hFFFF_FE00) | {23'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VERTEX_COUNT:  cfg_vertex_count  = value;
            REG_MIN_DEGREE:    cfg_min_degree    = value;
            REG_MIN_NONDEGREE: cfg_min_nondegree = value;
            default: ;
        endcase
    endtask

    task automatic push_word(input logic [7:0] a, input logic [7:0] b,
                             input logic has, input logic last);
        edge_word_t w;
        w.end_a     = a;
        w.end_b     = b;
        w.has_edge  = has;
        w.last_item = last;
        edge_words  = {edge_words, w};
    endtask

    // idle only once every queued word is in and every count is back;
    // the pause covers a trailing edge word still being written
    task automatic wait_drained();
        @(negedge aclk);
        while (edge_words.size() != 0 || s_valid || survivor_counts.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic pick_config(output int unsigned n_lim);
        int unsigned roll;
        int unsigned vc;
        int unsigned md;
        int unsigned mn;
        roll = $urandom_range(99);
        if (roll < 14) begin
            // big graphs: keep bounds so the peel settles in one or two passes
            vc = (roll < 8) ? $urandom_range(256, 511) : $urandom_range(100, 255);
            md = $urandom_range(1);
            mn = $urandom_range(1) ? 0 : 511;
        end else if (roll < 17) begin
            vc = $urandom_range(1);
            md = $urandom_range(2);
            mn = $urandom_range(2);
        end else begin
            vc = $urandom_range(2, 24);
            md = $urandom_range(vc / 2 + 1);
            mn = $urandom_range(vc / 2 + 1);
            if ($urandom_range(19) == 0) md = 511;
            if ($urandom_range(19) == 0) mn = 256;
        end
        write_reg(REG_VERTEX_COUNT, vc[8:0]);
        write_reg(REG_MIN_DEGREE, md[8:0]);
        write_reg(REG_MIN_NONDEGREE, mn[8:0]);
        n_lim = (vc > MAXV) ? MAXV : vc;
    endtask

    // mostly in-range edges; some empty words, self-loops and stray endpoints
    task automatic queue_graph(input int unsigned n_lim);
        int unsigned n_edges;
        int unsigned hi;
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        int unsigned top;
        top = (n_lim == 0) ? 255 : n_lim - 1;
        if (n_lim < 2)        hi = 3;
        else if (n_lim >= 100) hi = 150;
        else if (n_lim < 12)  hi = n_lim * (n_lim - 1) / 2 + 2;
        else                  hi = 60;
        n_edges = $urandom_range(1, hi);
        for (int unsigned i = 0; i < n_edges; i++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                push_word($urandom_range(255), $urandom_range(255), 1'b0, i == n_edges - 1);
            end else if (pick < 10) begin
                a = $urandom_range(top);
                push_word(a[7:0], a[7:0], 1'b1, i == n_edges - 1);
            end else if (pick < 16 || n_lim < 2) begin
                a = $urandom_range(top);
                b = (n_lim < 256) ? $urandom_range(n_lim, 255) : $urandom_range(255);
                if ($urandom_range(1)) push_word(a[7:0], b[7:0], 1'b1, i == n_edges - 1);
                else                   push_word(b[7:0], a[7:0], 1'b1, i == n_edges - 1);
            end else begin
                a = $urandom_range(n_lim - 1);
                b = $urandom_range(n_lim - 1);
                if (a == b) b = (a + 1) % n_lim;
                push_word(a[7:0], b[7:0], 1'b1, i == n_edges - 1);
            end
            edges_loaded++;
        end
    endtask

    initial begin
        int unsigned n_lim;
        int unsigned n_graphs;
        bit          first_phase;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset config: full 256 vertices, no bounds
        push_word(8'd0, 8'd255, 1'b1, 1'b0);
        push_word(8'd255, 8'd0, 1'b1, 1'b0);     // duplicate, reversed
        push_word(8'd7, 8'd7, 1'b1, 1'b0);       // self-loop
        push_word(8'd255, 8'd255, 1'b0, 1'b0);   // empty word
        push_word(8'd128, 8'd127, 1'b1, 1'b1);   // edge on the closing word
        wait_drained();

        write_reg(REG_VERTEX_COUNT, 9'd4);
        write_reg(REG_MIN_DEGREE, 9'd1);
        write_reg(REG_MIN_NONDEGREE, 9'd0);
        write_reg(REG_SPARE, 9'h1FF);
        push_word(8'd0, 8'd1, 1'b1, 1'b0);
        push_word(8'd2, 8'd9, 1'b1, 1'b0);       // endpoint past vertex count
        push_word(8'd0, 8'd0, 1'b0, 1'b1);
        wait_drained();

        // vertex count lowered mid-load drops edges into the cut vertices
        write_reg(REG_VERTEX_COUNT, 9'd8);
        write_reg(REG_MIN_DEGREE, 9'd2);
        push_word(8'd0, 8'd1, 1'b1, 1'b0);
        push_word(8'd1, 8'd2, 1'b1, 1'b0);
        push_word(8'd2, 8'd0, 1'b1, 1'b0);
        push_word(8'd2, 8'd6, 1'b1, 1'b0);
        push_word(8'd6, 8'd7, 1'b1, 1'b0);
        wait_drained();
        write_reg(REG_VERTEX_COUNT, 9'd3);
        push_word(8'd5, 8'd1, 1'b1, 1'b1);
        wait_drained();

        write_reg(REG_VERTEX_COUNT, 9'd0);
        push_word(8'd0, 8'd1, 1'b1, 1'b1);
        wait_drained();

        // count saturates; degree bound above the count clears everything
        write_reg(REG_VERTEX_COUNT, 9'd511);
        write_reg(REG_MIN_DEGREE, 9'd256);
        push_word(8'd3, 8'd4, 1'b1, 1'b1);
        wait_drained();

        write_reg(REG_VERTEX_COUNT, 9'd5);
        write_reg(REG_MIN_DEGREE, 9'd0);
        write_reg(REG_MIN_NONDEGREE, 9'd2);
        push_word(8'd0, 8'd1, 1'b1, 1'b0);
        push_word(8'd0, 8'd2, 1'b1, 1'b0);
        push_word(8'd3, 8'd0, 1'b1, 1'b0);
        push_word(8'd0, 8'd4, 1'b1, 1'b1);
        wait_drained();

        write_reg(REG_VERTEX_COUNT, 9'd1);
        write_reg(REG_MIN_NONDEGREE, 9'd0);
        push_word(8'd0, 8'd0, 1'b0, 1'b1);
        wait_drained();
        write_reg(REG_MIN_DEGREE, 9'd511);
        write_reg(REG_MIN_NONDEGREE, 9'd511);
        push_word(8'd0, 8'd0, 1'b0, 1'b1);
        wait_drained();

        edges_loaded = 0;
        first_phase = 1'b1;
        while (edges_loaded < RANDOM_EDGES) begin
            case ((edges_loaded * 4) / RANDOM_EDGES)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            pick_config(n_lim);
            n_graphs = $urandom_range(1, 3);
            if (first_phase) begin
                // receiver holds off while several graphs queue up behind it
                hold_start = 1'b1;
                n_graphs = 4;
                first_phase = 1'b0;
            end
            repeat (n_graphs) queue_graph(n_lim);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && survivor_counts.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
